// ===== sv/jfid_pkg.sv =====
// ----------------------------------------------------------------------------
// jfid_pkg: shared types and constants for the first-id extractor
// Byte classes, key tables, scan phases and queue sizing.
// ----------------------------------------------------------------------------
package jfid_pkg;

   localparam int MAX_ID_CHARS = 31;
   localparam int DEPTH_BITS   = 8;
   localparam int COUNT_BITS   = $clog2(MAX_ID_CHARS + 1);
   localparam int CHAR_W       = 8;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

   localparam int OUTER_LEN  = 7;
   localparam int INNER_LEN  = 4;
   localparam int MATCH_BITS = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_QUOTE    = 8'h22;
   localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_LBRACE   = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE   = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;

   // "prods" and "id", quotes included
   localparam logic [CHAR_W-1:0] OUTER_KEY [OUTER_LEN] =
      '{8'h22, 8'h70, 8'h72, 8'h6F, 8'h64, 8'h73, 8'h22};
   localparam logic [CHAR_W-1:0] INNER_KEY [INNER_LEN] =
      '{8'h22, 8'h69, 8'h64, 8'h22};

   typedef enum logic [2:0] {
      PH_SEARCH_OUTER,
      PH_WAIT_BRACKET,
      PH_SEARCH_ID,
      PH_WAIT_VALUE,
      PH_CAPTURE_STR,
      PH_CAPTURE_NUM,
      PH_ANSWERED
   } phase_type;

   // classified byte as it travels from front to back
   typedef struct packed {
      logic [CHAR_W-1:0]    text_byte;
      logic                 end_of_doc;
      logic                 is_digit;
      logic                 is_quote;
      logic                 is_lbracket;
      logic                 is_lbrace;
      logic                 is_rbrace;
      logic [OUTER_LEN-1:0] outer_hit;
      logic [INNER_LEN-1:0] inner_hit;
   } byte_info_type;

endpackage

// ===== sv/jfid_front.sv =====
// ----------------------------------------------------------------------------
// jfid_front: byte classifier
// Accepts input beats and tags each byte with the classes the scanner needs.
// ----------------------------------------------------------------------------
module jfid_front (
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [jfid_pkg::CHAR_W-1:0]           req_text_byte,
   input  logic                                  req_end_of_doc,
   input  logic                                  q_full,
   output logic                                  q_push,
   output jfid_pkg::byte_info_type               q_wdata
);

   always_comb begin
      q_wdata.text_byte   = req_text_byte;
      q_wdata.end_of_doc  = req_end_of_doc;
      q_wdata.is_digit    = req_text_byte inside {[jfid_pkg::CH_ZERO:jfid_pkg::CH_NINE]};
      q_wdata.is_quote    = (req_text_byte == jfid_pkg::CH_QUOTE);
      q_wdata.is_lbracket = (req_text_byte == jfid_pkg::CH_LBRACKET);
      q_wdata.is_lbrace   = (req_text_byte == jfid_pkg::CH_LBRACE);
      q_wdata.is_rbrace   = (req_text_byte == jfid_pkg::CH_RBRACE);
      for (int i = 0; i < jfid_pkg::OUTER_LEN; i++) begin
         q_wdata.outer_hit[i] = (req_text_byte == jfid_pkg::OUTER_KEY[i]);
      end
      for (int i = 0; i < jfid_pkg::INNER_LEN; i++) begin
         q_wdata.inner_hit[i] = (req_text_byte == jfid_pkg::INNER_KEY[i]);
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ===== sv/jfid_queue.sv =====
// ----------------------------------------------------------------------------
// jfid_queue: short FIFO between classifier and scanner
// Lets the input side keep taking beats while the result side stalls.
// ----------------------------------------------------------------------------
module jfid_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  jfid_pkg::byte_info_type wdata,
   output logic                    full,
   input  logic                    pop,
   output logic                    not_empty,
   output jfid_pkg::byte_info_type rdata
);

   jfid_pkg::byte_info_type              entry_ff [jfid_pkg::QUEUE_DEPTH];
   logic [jfid_pkg::QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [jfid_pkg::QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [jfid_pkg::QCNT_BITS-1:0]       count_ff, count_in;
   logic                                 do_push, do_pop;

   assign full      = (count_ff == jfid_pkg::QCNT_BITS'(jfid_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rdata     = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== sv/jfid_back.sv =====
// ----------------------------------------------------------------------------
// jfid_back: scanner and result register
// Walks the key / bracket / id / value phases and drives the result beat.
// ----------------------------------------------------------------------------
module jfid_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   input  jfid_pkg::byte_info_type       q_rdata,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [jfid_pkg::CHAR_W-1:0]   rsp_id_char,
   output logic                          rsp_char_valid,
   output logic                          rsp_finished,
   output logic                          rsp_outcome
);

   jfid_pkg::phase_type                  phase_ff, phase_in;
   logic [jfid_pkg::MATCH_BITS-1:0]      pos_ff, pos_in;
   logic [jfid_pkg::DEPTH_BITS-1:0]      depth_ff, depth_in;
   logic [jfid_pkg::COUNT_BITS-1:0]      count_ff, count_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [jfid_pkg::CHAR_W-1:0]          id_char_ff;
   logic                                 char_valid_ff, finished_ff, outcome_ff;

   logic                                 take;
   logic                                 have_char, fin, notfound;
   logic                                 rbrace_close;

   assign take  = q_not_empty && (!rsp_valid_ff || rsp_ready);
   assign q_pop = take;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      have_char    = 1'b0;
      fin          = 1'b0;
      notfound     = 1'b0;
      rbrace_close = 1'b0;

      case (phase_ff)
         jfid_pkg::PH_SEARCH_OUTER: begin
            if (q_rdata.outer_hit[pos_ff]) begin
               if (pos_ff == jfid_pkg::MATCH_BITS'(jfid_pkg::OUTER_LEN - 1)) begin
                  pos_in   = '0;
                  phase_in = jfid_pkg::PH_WAIT_BRACKET;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end else begin
               // restart: a mismatching quote counts as the key's first byte
               pos_in = jfid_pkg::MATCH_BITS'(q_rdata.outer_hit[0]);
            end
         end
         jfid_pkg::PH_WAIT_BRACKET: begin
            if (q_rdata.is_lbracket) begin
               phase_in = jfid_pkg::PH_SEARCH_ID;
               pos_in   = '0;
               depth_in = '0;
            end
         end
         jfid_pkg::PH_SEARCH_ID: begin
            if (q_rdata.is_lbrace) begin
               if (depth_ff != jfid_pkg::DEPTH_MAX) begin
                  depth_in = depth_ff + 1'b1;
               end
            end else if (q_rdata.is_rbrace) begin
               if (depth_ff <= jfid_pkg::DEPTH_BITS'(1)) begin
                  rbrace_close = 1'b1;
               end else begin
                  depth_in = depth_ff - 1'b1;
               end
            end
            if (rbrace_close) begin
               // first object closed without an id
               fin      = 1'b1;
               notfound = 1'b1;
               phase_in = jfid_pkg::PH_ANSWERED;
            end else if (q_rdata.inner_hit[pos_ff[1:0]]) begin
               if (pos_ff == jfid_pkg::MATCH_BITS'(jfid_pkg::INNER_LEN - 1)) begin
                  pos_in   = '0;
                  phase_in = jfid_pkg::PH_WAIT_VALUE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end else begin
               pos_in = jfid_pkg::MATCH_BITS'(q_rdata.inner_hit[0]);
            end
         end
         jfid_pkg::PH_WAIT_VALUE: begin
            if (q_rdata.is_quote) begin
               phase_in = jfid_pkg::PH_CAPTURE_STR;
               count_in = '0;
            end else if (q_rdata.is_digit) begin
               phase_in  = jfid_pkg::PH_CAPTURE_NUM;
               count_in  = jfid_pkg::COUNT_BITS'(1);
               have_char = 1'b1;
               if (count_in >= jfid_pkg::COUNT_BITS'(jfid_pkg::MAX_ID_CHARS)) begin
                  fin      = 1'b1;
                  phase_in = jfid_pkg::PH_ANSWERED;
               end
            end
         end
         jfid_pkg::PH_CAPTURE_STR: begin
            if (q_rdata.is_quote) begin
               fin      = 1'b1;
               notfound = (count_ff == '0);
               phase_in = jfid_pkg::PH_ANSWERED;
            end else begin
               have_char = 1'b1;
               count_in  = count_ff + 1'b1;
               if (count_in >= jfid_pkg::COUNT_BITS'(jfid_pkg::MAX_ID_CHARS)) begin
                  fin      = 1'b1;
                  phase_in = jfid_pkg::PH_ANSWERED;
               end
            end
         end
         jfid_pkg::PH_CAPTURE_NUM: begin
            if (q_rdata.is_digit) begin
               have_char = 1'b1;
               count_in  = count_ff + 1'b1;
               if (count_in >= jfid_pkg::COUNT_BITS'(jfid_pkg::MAX_ID_CHARS)) begin
                  fin      = 1'b1;
                  phase_in = jfid_pkg::PH_ANSWERED;
               end
            end else begin
               fin      = 1'b1;
               phase_in = jfid_pkg::PH_ANSWERED;
            end
         end
         default: begin
         end
      endcase

      // last byte: close the answer if still open, then rearm
      if (q_rdata.end_of_doc) begin
         if (!fin && phase_in != jfid_pkg::PH_ANSWERED) begin
            fin      = 1'b1;
            notfound = !((phase_in == jfid_pkg::PH_CAPTURE_STR ||
                          phase_in == jfid_pkg::PH_CAPTURE_NUM) && count_in != '0);
         end
         phase_in = jfid_pkg::PH_SEARCH_OUTER;
         pos_in   = '0;
         depth_in = '0;
         count_in = '0;
      end

      if (take) begin
         rsp_valid_in = have_char || fin;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jfid_pkg::PH_SEARCH_OUTER;
         pos_ff       <= '0;
         depth_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            depth_ff <= depth_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         id_char_ff    <= have_char ? q_rdata.text_byte : '0;
         char_valid_ff <= have_char;
         finished_ff   <= fin;
         outcome_ff    <= fin && notfound;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_id_char    = id_char_ff;
   assign rsp_char_valid = char_valid_ff;
   assign rsp_finished   = finished_ff;
   assign rsp_outcome    = outcome_ff;

endmodule

// ===== sv/json_first_id_extractor.sv =====
// ----------------------------------------------------------------------------
// json_first_id_extractor: first "id" value under "prods"
// Scans a JSON byte stream and returns the first object's id characters
// followed by a found / not-found status.
// ----------------------------------------------------------------------------
//  channel | ports                                        | dir | beat
//  req     | req_valid/ready, req_text_byte, req_end_of_doc | in  | one byte
//  rsp     | rsp_valid/ready, rsp_id_char, rsp_char_valid, | out | char and/or
//          | rsp_finished, rsp_outcome                    |     | status
//
// One byte per cycle sustained while rsp does not stall. A byte is
// classified on acceptance, waits in a 4-entry queue, and the scanner
// retires one per cycle into the result register unless rsp stalls;
// when idle a byte goes through the queue entry, then the result register.
// Bytes that produce nothing still pass through the scanner.
// When rsp stalls the queue fills; req_ready drops only when it is full.
// Synchronous reset returns to the outer key search with the queue empty.
// ----------------------------------------------------------------------------
module json_first_id_extractor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [jfid_pkg::CHAR_W-1:0]   req_text_byte,
   input  logic                          req_end_of_doc,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [jfid_pkg::CHAR_W-1:0]   rsp_id_char,
   output logic                          rsp_char_valid,
   output logic                          rsp_finished,
   output logic                          rsp_outcome
);

   jfid_pkg::byte_info_type q_wdata, q_rdata;
   logic                    q_push, q_pop, q_full, q_not_empty;

   jfid_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_end_of_doc (req_end_of_doc),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_wdata        (q_wdata)
   );

   jfid_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   jfid_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_rdata        (q_rdata),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_id_char    (rsp_id_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_finished   (rsp_finished),
      .rsp_outcome    (rsp_outcome)
   );

endmodule
